// ===== hw/rtl/mlf_pkg.sv =====
package mlf_pkg;

  localparam int IO_WIDTH = 18;
  localparam int QDEPTH   = 2;

  typedef struct packed {
    logic signed [IO_WIDTH-1:0] audio;
    logic signed [IO_WIDTH-1:0] cutoff;
    logic        [IO_WIDTH-1:0] resonance;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== hw/rtl/moog_ladder_lowpass_filter.sv =====
// each sample is popped from the queue, then runs through 19 multiplies in turn on the single shared
//   multiplier, then is registered at the output; the ladder works on one sample at a time
// a two-beat queue takes new samples while the ladder works and a result waits
// reset (synchronous, active high) clears the ladder state and sets safety_enable
module moog_ladder_lowpass_filter
  import mlf_pkg::*;
#(
  parameter int FRAC_BITS   = 16,
  parameter int STATE_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic                       cfg_write_data,
  input  logic                       sample_valid,
  output logic                       sample_ready,
  input  logic signed [IO_WIDTH-1:0] audio_in,
  input  logic signed [IO_WIDTH-1:0] cutoff,
  input  logic        [IO_WIDTH-1:0] resonance,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic signed [IO_WIDTH-1:0] audio_out
);

  q_status_t q_stat;
  item_t     wr_item;
  item_t     head;
  logic      push;
  logic      pop;

  mlf_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .sample_valid  (sample_valid),
    .sample_ready  (sample_ready),
    .audio_in      (audio_in),
    .cutoff        (cutoff),
    .resonance     (resonance),
    .q_stat        (q_stat),
    .push          (push),
    .item          (wr_item)
  );

  mlf_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_item(wr_item),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  mlf_back #(
    .FRAC_BITS  (FRAC_BITS),
    .STATE_WIDTH(STATE_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_stat      (q_stat),
    .head        (head),
    .pop         (pop),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .audio_out   (audio_out)
  );

endmodule

// ===== hw/rtl/mlf_front.sv =====
module mlf_front
  import mlf_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic                       cfg_write_data,
  input  logic                       sample_valid,
  output logic                       sample_ready,
  input  logic signed [IO_WIDTH-1:0] audio_in,
  input  logic signed [IO_WIDTH-1:0] cutoff,
  input  logic        [IO_WIDTH-1:0] resonance,
  input  q_status_t                  q_stat,
  output logic                       push,
  output item_t                      item
);

  localparam longint ONE_L = longint'(1) << FRAC_BITS;
  localparam logic signed [IO_WIDTH-1:0] ONE_IO = IO_WIDTH'(ONE_L);

  logic safety_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      safety_enable <= 1'b1;
    end else if (cfg_write_en) begin
      safety_enable <= cfg_write_data;
    end
  end

  // cutoff clamp to zero..one when safe mode is on
  always_comb begin
    item.audio     = audio_in;
    item.resonance = resonance;
    item.cutoff    = cutoff;
    if (safety_enable) begin
      if (cutoff[IO_WIDTH-1]) begin
        item.cutoff = '0;
      end else if (longint'(cutoff) > ONE_L) begin
        item.cutoff = ONE_IO;
      end
    end
  end

  assign sample_ready = !q_stat.full;
  assign push         = sample_valid && !q_stat.full;

endmodule

// ===== hw/rtl/mlf_queue.sv =====
module mlf_queue
  import mlf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  item_t     wr_item,
  input  logic      pop,
  output item_t     head,
  output q_status_t q_stat
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  item_t          entry [QDEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [CW-1:0]  count;

  assign head         = entry[rptr];
  assign q_stat.full  = (count == CW'(QDEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= wr_item;
    end
  end

endmodule

// ===== hw/rtl/mlf_mul.sv =====
module mlf_mul #(
  parameter int FRAC_BITS   = 16,
  parameter int STATE_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [((STATE_WIDTH > FRAC_BITS + 3) ?
                        STATE_WIDTH : FRAC_BITS + 3):0] a,
  input  logic signed [((STATE_WIDTH > FRAC_BITS + 3) ?
                        STATE_WIDTH : FRAC_BITS + 3):0] b,
  output logic                                  done,
  output logic signed [STATE_WIDTH-1:0]         res
);

  localparam int SW  = STATE_WIDTH;
  localparam int MW  = (SW > FRAC_BITS + 3) ? SW : FRAC_BITS + 3;
  localparam int NCH = (MW + 31) / 32;
  localparam int CH  = (MW + NCH - 1) / NCH;
  localparam int UBW = NCH * CH;
  localparam int PW  = MW + UBW;
  localparam int CW  = $clog2(NCH + 1);

  localparam logic [PW:0] RND  = (PW+1)'(1) << (FRAC_BITS - 1);
  localparam logic [PW:0] LIMP = (PW+1)'(1) << (SW - 1);

  logic [MW-1:0]    ua;
  logic [UBW-1:0]   ub;
  logic [PW-1:0]    acc;
  logic             neg;
  logic [CW-1:0]    cnt;
  logic             rnd;

  logic signed [MW:0] a_abs;
  logic signed [MW:0] b_abs;
  logic [MW+CH-1:0]   part;
  logic [PW:0]        rsum;
  logic [PW:0]        rq;
  logic [PW:0]        lim;
  logic [PW:0]        mag;

  assign a_abs = a[MW] ? -a : a;
  assign b_abs = b[MW] ? -b : b;
  assign part  = ua * ub[UBW-1 -: CH];
  assign rsum  = {1'b0, acc} + RND;
  assign rq    = rsum >> FRAC_BITS;
  assign lim   = neg ? LIMP : LIMP - 1'b1;
  assign mag   = (rq > lim) ? lim : rq;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      rnd  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && (cnt == '0) && rnd;
      if (start) begin
        cnt <= CW'(NCH);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          rnd <= 1'b1;
        end
      end else if (rnd) begin
        rnd <= 1'b0;
      end
    end
  end

  // partial products, most significant chunk first
  always_ff @(posedge clk) begin
    if (start) begin
      ua  <= a_abs[MW-1:0];
      ub  <= UBW'(b_abs[MW-1:0]);
      acc <= '0;
      neg <= a[MW] != b[MW];
    end else if (cnt != '0) begin
      acc <= (acc << CH) + PW'(part);
      ub  <= ub << CH;
    end else if (rnd) begin
      res <= neg ? -$signed(mag[SW-1:0]) : $signed(mag[SW-1:0]);
    end
  end

endmodule

// ===== hw/rtl/mlf_back.sv =====
module mlf_back
  import mlf_pkg::*;
#(
  parameter int FRAC_BITS   = 16,
  parameter int STATE_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  q_status_t                  q_stat,
  input  item_t                      head,
  output logic                       pop,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic signed [IO_WIDTH-1:0] audio_out
);

  localparam int SW = STATE_WIDTH;
  localparam int MW = (SW > FRAC_BITS + 3) ? SW : FRAC_BITS + 3;
  localparam int EW = MW + 2;

  localparam longint ONE_L  = longint'(1) << FRAC_BITS;
  localparam longint HALF_L = ONE_L >> 1;
  localparam longint C08_L  = (4 * ONE_L + 2) / 5;
  localparam longint C56_L  = (28 * ONE_L + 2) / 5;
  localparam longint CLIM_L = (19 * ONE_L + 10) / 20;
  localparam longint C001_L = (ONE_L + 50) / 100;
  localparam longint SMAX_L = (longint'(1) << (SW - 1)) - 1;

  localparam logic signed [MW:0]   C08_M  = (MW+1)'(C08_L);
  localparam logic signed [MW:0]   C56_M  = (MW+1)'(C56_L);
  localparam logic signed [MW:0]   HALF_M = (MW+1)'(HALF_L);
  localparam logic signed [MW:0]   C001_M = (MW+1)'(C001_L);
  localparam logic signed [EW-1:0] ONE_E  = EW'(ONE_L);
  localparam logic signed [EW-1:0] CLIM_E = EW'(CLIM_L);
  localparam logic signed [EW-1:0] SMAX_E = EW'(SMAX_L);
  localparam logic signed [EW-1:0] SMIN_E = ~SMAX_E;
  localparam logic signed [SW-1:0] SMAX_S = SW'(SMAX_L);
  localparam logic signed [SW-1:0] SMIN_S = ~SMAX_S;
  localparam logic signed [SW-1:0] OMAX_S = SW'(131071);
  localparam logic signed [SW-1:0] OMIN_S = SW'(-131072);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_M1   = 5'd1;
  localparam logic [4:0] ST_M2   = 5'd2;
  localparam logic [4:0] ST_M3   = 5'd3;
  localparam logic [4:0] ST_M4   = 5'd4;
  localparam logic [4:0] ST_M5   = 5'd5;
  localparam logic [4:0] ST_M6   = 5'd6;
  localparam logic [4:0] ST_M7   = 5'd7;
  localparam logic [4:0] ST_M8   = 5'd8;
  localparam logic [4:0] ST_M9   = 5'd9;
  localparam logic [4:0] ST_M10  = 5'd10;
  localparam logic [4:0] ST_M11  = 5'd11;
  localparam logic [4:0] ST_M12  = 5'd12;
  localparam logic [4:0] ST_M13  = 5'd13;
  localparam logic [4:0] ST_M14  = 5'd14;
  localparam logic [4:0] ST_M15  = 5'd15;
  localparam logic [4:0] ST_M16  = 5'd16;
  localparam logic [4:0] ST_M17  = 5'd17;
  localparam logic [4:0] ST_M18  = 5'd18;
  localparam logic [4:0] ST_M19  = 5'd19;
  localparam logic [4:0] ST_OUT  = 5'd20;

  function automatic logic signed [EW-1:0] ew(input logic signed [SW-1:0] v);
    return EW'(v);
  endfunction

  function automatic logic signed [SW-1:0] sat_e(input logic signed [EW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > SMAX_E) begin
      r = SMAX_S;
    end else if (v < SMIN_E) begin
      r = SMIN_S;
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  logic [4:0] state;
  logic       pend;
  logic       res_valid;

  logic signed [SW-1:0] delayed_input;
  logic signed [SW-1:0] stage_one;
  logic signed [SW-1:0] stage_two;
  logic signed [SW-1:0] stage_three;
  logic signed [SW-1:0] stage_four;

  logic signed [IO_WIDTH-1:0] x;
  logic signed [IO_WIDTH-1:0] fc;
  logic        [IO_WIDTH-1:0] rr;
  logic signed [SW-1:0]       q0;
  logic signed [SW-1:0]       p;
  logic signed [SW-1:0]       k;
  logic signed [SW-1:0]       inner;
  logic signed [SW-1:0]       g;
  logic signed [SW-1:0]       tmp;
  logic signed [SW-1:0]       acc;
  logic signed [SW-1:0]       u;
  logic signed [SW-1:0]       y;
  logic signed [IO_WIDTH-1:0] res_data;

  logic                 is_step;
  logic                 mul_start;
  logic                 mul_done;
  logic                 consume;
  logic                 out_load;
  logic signed [MW:0]   op_a;
  logic signed [MW:0]   op_b;
  logic signed [SW-1:0] m;

  logic signed [SW-1:0]       q0_n;
  logic signed [SW-1:0]       p_n;
  logic signed [SW-1:0]       k_n;
  logic signed [SW-1:0]       inner_n;
  logic signed [SW-1:0]       g1_n;
  logic signed [SW-1:0]       u_n;
  logic signed [SW-1:0]       d_n;
  logic signed [SW-1:0]       st_n;
  logic signed [SW-1:0]       s_old;
  logic signed [SW-1:0]       ss_n;
  logic signed [EW-1:0]       st_e;
  logic signed [EW-1:0]       ycl_e;
  logic signed [SW-1:0]       y_n;
  logic signed [SW-1:0]       yf_n;
  logic signed [IO_WIDTH-1:0] o18;

  assign is_step   = (state >= ST_M1) && (state <= ST_M19);
  assign mul_start = is_step && !pend;
  assign consume   = is_step && pend && mul_done;
  assign pop       = (state == ST_IDLE) && !q_stat.empty;
  assign out_load  = (state == ST_OUT) && (!res_valid || result_ready);

  assign result_valid = res_valid;
  assign audio_out    = res_data;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      ST_M1: begin
        op_a = C08_M;
        op_b = (MW+1)'(fc);
      end
      ST_M2, ST_M4: begin
        op_a = (MW+1)'(tmp);
        op_b = (MW+1)'(q0);
      end
      ST_M3: begin
        op_a = C56_M;
        op_b = (MW+1)'(q0);
      end
      ST_M5: begin
        op_a = HALF_M;
        op_b = (MW+1)'(q0);
      end
      ST_M6: begin
        op_a = (MW+1)'(tmp);
        op_b = (MW+1)'(inner);
      end
      ST_M7: begin
        op_a = (MW+1)'(rr);
        op_b = (MW+1)'(tmp);
      end
      ST_M8: begin
        op_a = (MW+1)'(g);
        op_b = (MW+1)'(stage_four);
      end
      ST_M9, ST_M11, ST_M13, ST_M15: begin
        op_a = (MW+1)'(acc);
        op_b = (MW+1)'(p);
      end
      ST_M10: begin
        op_a = (MW+1)'(stage_one);
        op_b = (MW+1)'(k);
      end
      ST_M12: begin
        op_a = (MW+1)'(stage_two);
        op_b = (MW+1)'(k);
      end
      ST_M14: begin
        op_a = (MW+1)'(stage_three);
        op_b = (MW+1)'(k);
      end
      ST_M16: begin
        op_a = (MW+1)'(stage_four);
        op_b = (MW+1)'(k);
      end
      ST_M17: begin
        op_a = (MW+1)'(y);
        op_b = (MW+1)'(y);
      end
      ST_M18: begin
        op_a = (MW+1)'(tmp);
        op_b = (MW+1)'(y);
      end
      ST_M19: begin
        op_a = (MW+1)'(tmp);
        op_b = C001_M;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  mlf_mul #(
    .FRAC_BITS  (FRAC_BITS),
    .STATE_WIDTH(STATE_WIDTH)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (op_a),
    .b    (op_b),
    .done (mul_done),
    .res  (m)
  );

  always_comb begin
    case (state)
      ST_M10:  s_old = stage_one;
      ST_M12:  s_old = stage_two;
      ST_M14:  s_old = stage_three;
      default: s_old = stage_four;
    endcase
  end

  assign q0_n    = sat_e(ONE_E - EW'(head.cutoff));
  assign p_n     = sat_e(EW'(fc) + ew(m));
  assign k_n     = sat_e(ew(sat_e(ew(p) + ew(p))) - ONE_E);
  assign inner_n = sat_e(ew(sat_e(ONE_E - ew(q0))) + ew(m));
  assign g1_n    = sat_e(ONE_E + ew(m));
  assign u_n     = sat_e(EW'(x) - ew(m));
  assign d_n     = sat_e(ew(u_n) + ew(delayed_input));
  assign st_n    = sat_e(ew(tmp) - ew(m));
  assign ss_n    = sat_e(ew(st_n) + ew(s_old));
  assign st_e    = ew(st_n);
  assign yf_n    = sat_e(ew(y) - ew(m));

  // last stage clamp to plus or minus 0.95
  always_comb begin
    if (st_e > CLIM_E) begin
      ycl_e = CLIM_E;
    end else if (st_e < -CLIM_E) begin
      ycl_e = -CLIM_E;
    end else begin
      ycl_e = st_e;
    end
  end
  assign y_n = ycl_e[SW-1:0];

  always_comb begin
    if (y > OMAX_S) begin
      o18 = OMAX_S[IO_WIDTH-1:0];
    end else if (y < OMIN_S) begin
      o18 = OMIN_S[IO_WIDTH-1:0];
    end else begin
      o18 = y[IO_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pend          <= 1'b0;
      res_valid     <= 1'b0;
      delayed_input <= '0;
      stage_one     <= '0;
      stage_two     <= '0;
      stage_three   <= '0;
      stage_four    <= '0;
    end else begin
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (result_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            state <= ST_M1;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          if (!pend) begin
            pend <= 1'b1;
          end else if (mul_done) begin
            pend  <= 1'b0;
            state <= state + 5'd1;
            case (state)
              ST_M10:  stage_one   <= st_n;
              ST_M12:  stage_two   <= st_n;
              ST_M14:  stage_three <= st_n;
              ST_M19: begin
                stage_four    <= yf_n;
                delayed_input <= u;
              end
              default: begin
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      x  <= head.audio;
      fc <= head.cutoff;
      rr <= head.resonance;
      q0 <= q0_n;
    end
    if (consume) begin
      case (state)
        ST_M2: p <= p_n;
        ST_M4: begin
          inner <= inner_n;
          k     <= k_n;
        end
        ST_M6: tmp <= g1_n;
        ST_M7: g <= m;
        ST_M8: begin
          u   <= u_n;
          acc <= d_n;
        end
        ST_M10, ST_M12, ST_M14: acc <= ss_n;
        ST_M16: y <= y_n;
        ST_M19: y <= yf_n;
        default: tmp <= m;
      endcase
    end
    if (out_load) begin
      res_data <= o18;
    end
  end

endmodule

// ===== hw/rtl/mlf_checker.sv =====
module mlf_checker
  import mlf_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       sample_valid,
  input logic                       sample_ready,
  input logic                       result_valid,
  input logic                       result_ready,
  input logic signed [IO_WIDTH-1:0] audio_out
);

  // queue entries plus one in the ladder plus one waiting at the output
  localparam int MAX_OUT = QDEPTH + 2;
  localparam int OW      = $clog2(MAX_OUT + 1);

  logic [OW-1:0] outstanding;
  logic          beat_in;
  logic          beat_out;

  assign beat_in  = sample_valid && sample_ready;
  assign beat_out = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (beat_in && !beat_out) begin
      outstanding <= outstanding + 1'b1;
    end else if (beat_out && !beat_in) begin
      outstanding <= outstanding - 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(audio_out))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid && sample_ready)
    else $error("bad state after reset");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> outstanding != '0)
    else $error("result with no sample taken");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    outstanding == OW'(MAX_OUT) |-> !sample_ready)
    else $error("more samples taken than the block can hold");

endmodule

bind moog_ladder_lowpass_filter mlf_checker u_mlf_checker (.*);

// ===== verif/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mlf_pkg::*;

  localparam int FRAC_BITS      = 16;
  localparam int STATE_WIDTH    = 32;
  localparam int SETTLE_CYCLES  = 100;
  localparam int WATCHDOG_LIMIT = 3000;

  localparam longint ONE_Q   = longint'(1) << FRAC_BITS;
  localparam longint HALF_Q  = ONE_Q >>> 1;
  localparam longint C_0P8   = (4 * ONE_Q + 2) / 5;
  localparam longint C_5P6   = (28 * ONE_Q + 2) / 5;
  localparam longint C_LIM   = (19 * ONE_Q + 10) / 20;
  localparam longint C_0P01  = (ONE_Q + 50) / 100;
  localparam longint S_MAX   = (longint'(1) << (STATE_WIDTH - 1)) - 1;
  localparam longint S_MIN   = -S_MAX - 1;
  localparam longint OUT_MAX = (longint'(1) << (IO_WIDTH - 1)) - 1;
  localparam longint OUT_MIN = -OUT_MAX - 1;
  localparam int     IO_MAX  = (1 << (IO_WIDTH - 1)) - 1;
  localparam int     IO_MIN  = -IO_MAX - 1;
  localparam int     RES_MAX = (1 << IO_WIDTH) - 1;

  typedef enum logic [1:0] {
    ENT_SAMPLE,
    ENT_CFG,
    ENT_DRAIN,
    ENT_PACE
  } entry_kind_t;

  typedef struct packed {
    entry_kind_t kind;
    item_t       smp;
    logic        cfg_value;
    logic [6:0]  send_idle;
    logic [6:0]  recv_idle;
  } stim_entry_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_write_en;
  logic                       cfg_write_data;
  logic                       sample_valid;
  logic                       sample_ready;
  logic signed [IO_WIDTH-1:0] audio_in;
  logic signed [IO_WIDTH-1:0] cutoff;
  logic        [IO_WIDTH-1:0] resonance;
  logic                       result_valid;
  logic                       result_ready;
  logic signed [IO_WIDTH-1:0] audio_out;

  stim_entry_t                stim_q[$];
  logic signed [IO_WIDTH-1:0] expected_audio_q[$];

  logic   safety_on;
  longint delayed_in, ladder_one, ladder_two, ladder_three, ladder_four;

  logic sample_beat_seen;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   settle_count;
  int   idle_cycles;
  int   fail_count;

  moog_ladder_lowpass_filter #(
    .FRAC_BITS  (FRAC_BITS),
    .STATE_WIDTH(STATE_WIDTH)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .sample_valid  (sample_valid),
    .sample_ready  (sample_ready),
    .audio_in      (audio_in),
    .cutoff        (cutoff),
    .resonance     (resonance),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .audio_out     (audio_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clip_state(longint v);
    if (v > S_MAX) return S_MAX;
    if (v < S_MIN) return S_MIN;
    return v;
  endfunction

  // product rounded to nearest, ties away from zero, then saturated
  function automatic longint qmul(longint a, longint b);
    logic         neg;
    logic [127:0] ma;
    logic [127:0] mb;
    logic [127:0] prod;
    logic [127:0] lim;
    neg  = (a < 0) != (b < 0);
    ma   = (a < 0) ? 128'(-a) : 128'(a);
    mb   = (b < 0) ? 128'(-b) : 128'(b);
    prod = (ma * mb + (128'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    lim  = neg ? 128'(S_MAX) + 128'(1) : 128'(S_MAX);
    if (prod > lim) prod = lim;
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic logic signed [IO_WIDTH-1:0] ladder_lowpass_step(item_t s);
    longint x, fc, r, q0, p, k, inner, g, u, t1, t2, y;
    x  = longint'($signed(s.audio));
    fc = longint'($signed(s.cutoff));
    r  = longint'(s.resonance);
    if (safety_on) begin
      if (fc < 0) fc = 0;
      if (fc > ONE_Q) fc = ONE_Q;
    end
    q0    = clip_state(ONE_Q - fc);
    p     = clip_state(fc + qmul(qmul(C_0P8, fc), q0));
    k     = clip_state(clip_state(p + p) - ONE_Q);
    inner = clip_state(clip_state(ONE_Q - q0) + qmul(qmul(C_5P6, q0), q0));
    g     = qmul(r, clip_state(ONE_Q + qmul(qmul(HALF_Q, q0), inner)));

    u            = clip_state(x - qmul(g, ladder_four));
    t1           = ladder_one;
    ladder_one   = clip_state(qmul(clip_state(u + delayed_in), p) - qmul(ladder_one, k));
    t2           = ladder_two;
    ladder_two   = clip_state(qmul(clip_state(ladder_one + t1), p) - qmul(ladder_two, k));
    t1           = ladder_three;
    ladder_three = clip_state(qmul(clip_state(ladder_two + t2), p) - qmul(ladder_three, k));
    y            = clip_state(qmul(clip_state(ladder_three + t1), p) - qmul(ladder_four, k));

    if (y > C_LIM) y = C_LIM;
    if (y < -C_LIM) y = -C_LIM;
    y = clip_state(y - qmul(qmul(qmul(y, y), y), C_0P01));

    ladder_four = y;
    delayed_in  = u;

    if (y > OUT_MAX) y = OUT_MAX;
    if (y < OUT_MIN) y = OUT_MIN;
    return y[IO_WIDTH-1:0];
  endfunction

  function automatic int clip_io(int v);
    if (v > IO_MAX) return IO_MAX;
    if (v < IO_MIN) return IO_MIN;
    return v;
  endfunction

  task automatic push_sample(int a, int c, int r);
    stim_entry_t e;
    e = '0;
    e.kind          = ENT_SAMPLE;
    e.smp.audio     = a[IO_WIDTH-1:0];
    e.smp.cutoff    = c[IO_WIDTH-1:0];
    e.smp.resonance = r[IO_WIDTH-1:0];
    stim_q.push_back(e);
  endtask

  task automatic push_drain();
    stim_entry_t e;
    e = '0;
    e.kind = ENT_DRAIN;
    stim_q.push_back(e);
  endtask

  task automatic push_safety(logic v);
    stim_entry_t e;
    e = '0;
    e.kind      = ENT_CFG;
    e.cfg_value = v;
    push_drain();
    stim_q.push_back(e);
  endtask

  task automatic push_pace(int s, int r);
    stim_entry_t e;
    e = '0;
    e.kind      = ENT_PACE;
    e.send_idle = s[6:0];
    e.recv_idle = r[6:0];
    stim_q.push_back(e);
  endtask

  // mostly runs of held or drifting settings with bounded audio, some pure noise
  task automatic push_random(int n);
    int count;
    int len;
    int amp;
    int cut;
    int res;
    bit wobble_res;
    count = 0;
    while (count < n) begin
      if ($urandom_range(9) < 8) begin
        len        = $urandom_range(8, 48);
        amp        = 1 << $urandom_range(4, IO_WIDTH - 1);
        cut        = ($urandom_range(7) == 0) ? $urandom_range(0, RES_MAX) + IO_MIN
                                              : $urandom_range(0, int'(ONE_Q));
        res        = $urandom_range(0, RES_MAX);
        wobble_res = ($urandom_range(3) == 0);
        for (int i = 0; i < len && count < n; i++) begin
          cut = clip_io(cut + $urandom_range(0, 512) - 256);
          if (wobble_res) res = $urandom_range(0, RES_MAX);
          push_sample(clip_io($urandom_range(0, 2 * amp - 1) - amp), cut, res);
          count++;
        end
      end else begin
        push_sample($urandom_range(0, RES_MAX), $urandom_range(0, RES_MAX),
                    $urandom_range(0, RES_MAX));
        count++;
      end
    end
  endtask

  always @(negedge clk) begin : drive_samples
    stim_entry_t head;
    logic        next_valid;
    logic        next_cfg_en;
    if (!rst) begin
      next_valid       = sample_valid && !sample_beat_seen;
      next_cfg_en      = 1'b0;
      sample_beat_seen = 1'b0;
      if (!next_valid && stim_q.size() != 0) begin
        case (stim_q[0].kind)
          ENT_SAMPLE: begin
            if ($urandom_range(99) >= send_idle_pct) begin
              head = stim_q.pop_front();
              audio_in   <= head.smp.audio;
              cutoff     <= head.smp.cutoff;
              resonance  <= head.smp.resonance;
              next_valid = 1'b1;
            end
          end
          ENT_CFG: begin
            head = stim_q.pop_front();
            cfg_write_data <= head.cfg_value;
            next_cfg_en    = 1'b1;
          end
          ENT_DRAIN: begin
            if (expected_audio_q.size() == 0) begin
              if (settle_count >= SETTLE_CYCLES) begin
                settle_count = 0;
                head = stim_q.pop_front();
              end else begin
                settle_count++;
              end
            end
          end
          default: begin
            head = stim_q.pop_front();
            send_idle_pct = int'(head.send_idle);
            recv_idle_pct = int'(head.recv_idle);
          end
        endcase
      end
      sample_valid <= next_valid;
      cfg_write_en <= next_cfg_en;
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    logic signed [IO_WIDTH-1:0] want;
    logic                       any_beat;
    any_beat = 1'b0;
    if (rst) begin
      safety_on    = 1'b1;
      delayed_in   = 0;
      ladder_one   = 0;
      ladder_two   = 0;
      ladder_three = 0;
      ladder_four  = 0;
      idle_cycles  = 0;
    end else begin
      if (cfg_write_en) safety_on = cfg_write_data;
      if (sample_valid && sample_ready) begin
        expected_audio_q.push_back(ladder_lowpass_step('{audio_in, cutoff, resonance}));
        sample_beat_seen = 1'b1;
        any_beat         = 1'b1;
      end
      if (result_valid && result_ready) begin
        any_beat = 1'b1;
        if (expected_audio_q.size() == 0) begin
          $error("audio_out: no beat expected, got %0d", audio_out);
          fail_count++;
        end else begin
          want = expected_audio_q.pop_front();
          if (audio_out !== want) begin
            $error("audio_out: expected %0d, got %0d", want, audio_out);
            fail_count++;
          end
        end
      end
      idle_cycles = any_beat ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst              = 1'b1;
    cfg_write_en     = 1'b0;
    cfg_write_data   = 1'b0;
    sample_valid     = 1'b0;
    audio_in         = '0;
    cutoff           = '0;
    resonance        = '0;
    result_ready     = 1'b0;
    sample_beat_seen = 1'b0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    settle_count     = 0;
    fail_count       = 0;

    push_pace(33, 52);
    // safety on from reset: cutoff clamped at both ends, feedback driven hard
    push_sample(0, 0, 0);
    push_sample(IO_MAX, int'(ONE_Q), 0);
    push_sample(IO_MIN, int'(ONE_Q), 0);
    push_sample(IO_MAX, IO_MAX, RES_MAX);
    push_sample(IO_MIN, IO_MIN, RES_MAX);
    push_sample(IO_MAX, int'(ONE_Q), RES_MAX);
    push_sample(IO_MAX, int'(ONE_Q), RES_MAX);
    push_sample(IO_MIN, int'(ONE_Q), RES_MAX);
    push_sample(int'(ONE_Q), int'(HALF_Q), int'(2 * ONE_Q));
    push_sample(0, -1, RES_MAX);
    push_sample(0, int'(ONE_Q) + 1, 0);
    // safety off: cutoff used as given
    push_safety(1'b0);
    push_sample(IO_MAX, IO_MAX, RES_MAX);
    push_sample(IO_MIN, IO_MIN, RES_MAX);
    push_sample(IO_MAX, IO_MIN, 0);
    push_sample(IO_MIN, IO_MAX, 0);
    push_sample(0, -int'(ONE_Q), int'(ONE_Q));
    push_sample(int'(ONE_Q), 98304, 200000);
    push_sample(100000, -1, 1);
    push_sample(IO_MAX, IO_MAX, RES_MAX);
    push_sample(IO_MAX, IO_MAX, RES_MAX);
    push_sample(0, 0, 0);
    push_safety(1'b1);
    push_random(550);
    // hold off until every result is back
    push_drain();
    push_random(50);
    push_pace(52, 33);
    push_safety(1'b0);
    push_random(600);
    push_pace(0, 0);
    push_safety(1'b1);
    push_random(300);
    push_safety(1'b0);
    push_random(250);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0 || sample_valid || expected_audio_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (expected_audio_q.size() != 0) begin
      $error("audio_out: %0d beats never arrived", expected_audio_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
